/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
// Each check is clocked and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PLPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PLPD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PLPD_ASSERT(label, clk, rst, prop, msg)
`define PLPD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* sv/plpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plpd_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // Configuration register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

/* sv/plpd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Query point channel
interface plpd_point_if #(
  parameter int W = plpd_pkg::COORD_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] point_x;
  logic [W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// Projection result channel
interface plpd_result_if #(
  parameter int W = plpd_pkg::COORD_WIDTH
);
  logic         valid;
  logic         ready;
  logic [W-1:0] position_along;
  logic [W-1:0] distance;
  logic         degenerate_line;

  modport source (output valid, output position_along, output distance,
                  output degenerate_line, input ready);
  modport sink   (input valid, input position_along, input distance,
                  input degenerate_line, output ready);
endinterface

`default_nettype wire

/* sv/point_line_projection_distance.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Dir  Payload                                        Handshake
// point     in   point_x, point_y                               valid/ready
// result    out  position_along, distance, degenerate_line      valid/ready
// cfg       in   cfg_index, cfg_data                            cfg_write
//
// One item per cycle while the output skid register is empty. The pipeline holds
// the restoring divider for the squared distance (2*COORD_WIDTH+2 stages) and
// the square root (COORD_WIDTH+1 stages) that follows it.
// Reset is synchronous and clears the valid bits and the line registers.
// The whole pipeline stalls together while the output skid register is full.
module point_line_projection_distance #(
  parameter int COORD_WIDTH = plpd_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = plpd_pkg::FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  plpd_point_if.sink                                 point,
  plpd_result_if.source                              result,
  input  wire logic                                  cfg_write,
  input  wire logic [plpd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [COORD_WIDTH-1:0]                cfg_data
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = W + 1;             // coordinate difference
  localparam int PW2  = 2 * DW;            // signed product
  localparam int DENW = 2 * W + 1;         // squared length
  localparam int MAGW = 2 * W + 1;         // |dot|, |cross|, sum of squares
  localparam int LOW  = W + 1;             // low split of the square
  localparam int SQW  = 4 * W + 2;         // cross squared
  localparam int RDW  = 4 * W + 4;         // distance divider remainder
  localparam int KD   = 2 * W + 2;         // distance quotient bits
  localparam int XPW  = 2 * W + F + 3;     // position dividend
  localparam int RPW  = 3 * W + F + 3;     // position divider remainder
  localparam int TW   = KD + 1;            // square root trial

  typedef struct packed {
    logic [W-1:0] pos;
    logic [W-1:0] dst;
    logic         degen;
  } res_t;

  logic en;

  // Line registers
  logic [W-1:0] start_x;
  logic [W-1:0] start_y;
  logic [W-1:0] end_x;
  logic [W-1:0] end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (cfg_write) begin
      case (plpd_pkg::cfg_reg_t'(cfg_index))
        plpd_pkg::REG_START_X: start_x <= cfg_data;
        plpd_pkg::REG_START_Y: start_y <= cfg_data;
        plpd_pkg::REG_END_X:   end_x   <= cfg_data;
        plpd_pkg::REG_END_Y:   end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign point.ready = en;

  // Stage 0: differences from the line start
  logic                 v0;
  logic signed [DW-1:0] s0_px, s0_py, s0_dx, s0_dy;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= point.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_px <= $signed({point.point_x[W-1], point.point_x}) - $signed({start_x[W-1], start_x});
      s0_py <= $signed({point.point_y[W-1], point.point_y}) - $signed({start_y[W-1], start_y});
      s0_dx <= $signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x});
      s0_dy <= $signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y});
    end
  end

  // Stage 1: products
  logic                  v1, s1_degen;
  logic signed [PW2-1:0] s1_pxdx, s1_pydy, s1_pxdy, s1_pydx;
  logic signed [PW2-1:0] s1_dxdx, s1_dydy, s1_pxpx, s1_pypy;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pxdx  <= s0_px * s0_dx;
      s1_pydy  <= s0_py * s0_dy;
      s1_pxdy  <= s0_px * s0_dy;
      s1_pydx  <= s0_py * s0_dx;
      s1_dxdx  <= s0_dx * s0_dx;
      s1_dydy  <= s0_dy * s0_dy;
      s1_pxpx  <= s0_px * s0_px;
      s1_pypy  <= s0_py * s0_py;
      s1_degen <= (s0_dx == '0) && (s0_dy == '0);
    end
  end

  // Stage 2: dot, cross, squared length
  logic signed [PW2:0] dot_s, cross_s;
  logic [PW2:0]        dot_abs, cross_abs;
  logic [DENW-1:0]     len2, num;

  always_comb begin
    dot_s     = s1_pxdx + s1_pydy;
    cross_s   = s1_pxdy - s1_pydx;
    dot_abs   = dot_s[PW2] ? $unsigned(-dot_s) : $unsigned(dot_s);
    cross_abs = cross_s[PW2] ? $unsigned(-cross_s) : $unsigned(cross_s);
    len2      = {1'b0, s1_dxdx[2*W-1:0]} + {1'b0, s1_dydy[2*W-1:0]};
    num       = {1'b0, s1_pxpx[2*W-1:0]} + {1'b0, s1_pypy[2*W-1:0]};
  end

  logic            v2, s2_degen, s2_neg;
  logic [DENW-1:0] s2_den;
  logic [MAGW-1:0] s2_dot, s2_x;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_degen <= s1_degen;
      s2_neg   <= dot_s[PW2] && !s1_degen;
      s2_dot   <= dot_abs[MAGW-1:0];
      s2_den   <= s1_degen ? DENW'(1) : len2;
      s2_x     <= s1_degen ? num : cross_abs[MAGW-1:0];
    end
  end

  // Stage 3: partial products of the cross square
  logic                  v3, s3_degen, s3_neg;
  logic [DENW-1:0]       s3_den;
  logic [MAGW-1:0]       s3_dot, s3_x;
  logic [2*LOW-1:0]      s3_ll;
  logic [LOW+W-1:0]      s3_hl;
  logic [2*W-1:0]        s3_hh;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_degen <= s2_degen;
      s3_neg   <= s2_neg;
      s3_dot   <= s2_dot;
      s3_den   <= s2_den;
      s3_x     <= s2_x;
      s3_ll    <= s2_x[LOW-1:0] * s2_x[LOW-1:0];
      s3_hl    <= s2_x[MAGW-1:LOW] * s2_x[LOW-1:0];
      s3_hh    <= s2_x[MAGW-1:LOW] * s2_x[MAGW-1:LOW];
    end
  end

  // Stage 4: dividends
  logic [SQW-1:0] sq;

  always_comb begin
    sq = (SQW'(s3_hh) << (2 * LOW)) + (SQW'(s3_hl) << (LOW + 1)) + SQW'(s3_ll);
    if (s3_degen) sq = SQW'(s3_x);
  end

  logic            v4, s4_degen, s4_neg;
  logic [DENW-1:0] s4_den;
  logic [RDW-1:0]  s4_xd;
  logic [XPW-1:0]  s4_xp;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_degen <= s3_degen;
      s4_neg   <= s3_neg;
      s4_den   <= s3_den;
      s4_xd    <= {sq, 2'b00};
      s4_xp    <= (XPW'(s3_dot) << (F + 1)) + XPW'(s3_den);
    end
  end

  // Divider pipelines: element 0 holds the saturation checks
  logic            dv    [0:KD];
  logic            dsat  [0:KD];
  logic            psat  [0:KD];
  logic            dneg  [0:KD];
  logic            ddeg  [0:KD];
  logic [DENW-1:0] dden  [0:KD];
  logic [RDW-1:0]  dr    [0:KD];
  logic [KD-1:0]   dq    [0:KD];
  logic [RPW-1:0]  pr    [0:KD];
  logic [W-1:0]    pq    [0:KD];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsat[0] <= s4_xd >= (RDW'(s4_den) << KD);
      psat[0] <= RPW'(s4_xp) >= (RPW'(s4_den) << (W + 1));
      dneg[0] <= s4_neg;
      ddeg[0] <= s4_degen;
      dden[0] <= s4_den;
      dr[0]   <= s4_xd;
      dq[0]   <= '0;
      pr[0]   <= RPW'(s4_xp);
      pq[0]   <= '0;
    end
  end

  for (genvar j = 0; j < KD; j++) begin : g_div
    localparam int BD = KD - 1 - j;
    logic [RDW-1:0] dsh;
    logic           dge;
    logic [KD-1:0]  dq_next;

    // One quotient bit of the squared distance
    always_comb begin
      dsh        = RDW'(dden[j]) << BD;
      dge        = dr[j] >= dsh;
      dq_next    = dq[j];
      dq_next[BD] = dge;
    end

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsat[j+1] <= dsat[j];
        psat[j+1] <= psat[j];
        dneg[j+1] <= dneg[j];
        ddeg[j+1] <= ddeg[j];
        dden[j+1] <= dden[j];
        dr[j+1]   <= dge ? dr[j] - dsh : dr[j];
        dq[j+1]   <= dq_next;
      end
    end

    if (j < W) begin : g_pstep
      localparam int BP = W - 1 - j;
      logic [RPW-1:0] psh;
      logic           pge;
      logic [W-1:0]   pq_next;

      // One quotient bit of the position
      always_comb begin
        psh         = RPW'(dden[j]) << (BP + 1);
        pge         = pr[j] >= psh;
        pq_next     = pq[j];
        pq_next[BP] = pge;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pr[j+1] <= pge ? pr[j] - psh : pr[j];
          pq[j+1] <= pq_next;
        end
      end
    end else begin : g_phold
      always_ff @(posedge clk) begin
        if (en) begin
          pr[j+1] <= pr[j];
          pq[j+1] <= pq[j];
        end
      end
    end
  end

  // Square root pipeline over the clamped quotient
  logic [KD-1:0] sqm    [1:W+1];
  logic [W:0]    sqr    [1:W+1];
  logic          sqv    [1:W+1];
  logic          sqpsat [1:W+1];
  logic          sqneg  [1:W+1];
  logic          sqdeg  [1:W+1];
  logic [W-1:0]  sqpq   [1:W+1];

  for (genvar k = 0; k <= W; k++) begin : g_sqrt
    localparam int B = W - k;
    logic [KD-1:0] m_in;
    logic [W:0]    r_in;
    logic          v_in, psat_in, neg_in, deg_in;
    logic [W-1:0]  pq_in;
    logic [TW-1:0] trial;
    logic          ge;
    logic [W:0]    r_next;

    if (k == 0) begin : g_first
      assign m_in    = dsat[KD] ? '1 : dq[KD];
      assign r_in    = '0;
      assign v_in    = dv[KD];
      assign psat_in = psat[KD];
      assign neg_in  = dneg[KD];
      assign deg_in  = ddeg[KD];
      assign pq_in   = pq[KD];
    end else begin : g_next
      assign m_in    = sqm[k];
      assign r_in    = sqr[k];
      assign v_in    = sqv[k];
      assign psat_in = sqpsat[k];
      assign neg_in  = sqneg[k];
      assign deg_in  = sqdeg[k];
      assign pq_in   = sqpq[k];
    end

    // Try the next root bit against the remainder
    always_comb begin
      trial     = (TW'(r_in) << (B + 1)) | (TW'(1) << (2 * B));
      ge        = {1'b0, m_in} >= trial;
      r_next    = r_in;
      r_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) sqv[k+1] <= 1'b0;
      else if (en) sqv[k+1] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sqm[k+1]    <= ge ? m_in - trial[KD-1:0] : m_in;
        sqr[k+1]    <= r_next;
        sqpsat[k+1] <= psat_in;
        sqneg[k+1]  <= neg_in;
        sqdeg[k+1]  <= deg_in;
        sqpq[k+1]   <= pq_in;
      end
    end
  end

  // Final rounding and saturation
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  res_t        fin;
  logic [W+1:0] s_inc;
  logic [W:0]   d_w;
  logic [W-1:0] q_raw, q_lim;

  always_comb begin
    s_inc    = {1'b0, sqr[W+1]} + (W+2)'(1);
    d_w      = s_inc[W+1:1];
    fin.dst  = d_w[W] ? '1 : d_w[W-1:0];
    q_raw    = sqpsat[W+1] ? '1 : sqpq[W+1];
    if (sqdeg[W+1]) q_raw = '0;
    if (!sqneg[W+1]) begin
      q_lim   = (q_raw > HALF - W'(1)) ? HALF - W'(1) : q_raw;
      fin.pos = q_lim;
    end else begin
      q_lim   = (q_raw > HALF) ? HALF : q_raw;
      fin.pos = W'(0) - q_lim;
    end
    fin.degen = sqdeg[W+1];
  end

  // Output register and skid stage
  logic o_valid, s_valid, push;
  res_t o_data, s_data;

  assign en   = !s_valid;
  assign push = en && sqv[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (result.ready || !o_valid) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= push;
      end
    end else if (push) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !o_valid) begin
      o_data <= s_valid ? s_data : fin;
    end else if (push) begin
      s_data <= fin;
    end
  end

  assign result.valid           = o_valid;
  assign result.position_along  = o_data.pos;
  assign result.distance        = o_data.dst;
  assign result.degenerate_line = o_data.degen;

  `PLPD_ASSERT(a_skid_needs_out, clk, rst, s_valid |-> o_valid, "skid full without output")
  `PLPD_ASSERT(a_skid_on_stall, clk, rst, $rose(s_valid) |-> $past(o_valid && !result.ready), "skid filled without stall")
  `PLPD_ASSERT_NEVER(a_degen_pos, clk, rst, result.valid && result.degenerate_line && (result.position_along != '0), "degenerate line with nonzero position")

endmodule

`default_nettype wire
